FILE: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants for the census transform block
// Word layouts, register indexes, reset values and the cell band struct.
// ----------------------------------------------------------------------------
package ctc_pkg;

   // field widths
   localparam int PIX_W       = 8;
   localparam int CENSUS_W    = 49;
   localparam int CCOL_W      = 11;
   localparam int CROW_W      = 12;

   // configuration registers
   localparam int WIDTH_CFG_W = 12;
   localparam int DIAM_W      = 3;
   localparam int TOL_W       = 8;
   localparam int CSR_W       = 12;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_DIAMETER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE       = 2'd2;

   localparam logic [WIDTH_CFG_W-1:0] IMAGE_WIDTH_RST     = 12'd640;
   localparam logic [DIAM_W-1:0]      WINDOW_DIAMETER_RST = 3'd7;
   localparam logic [TOL_W-1:0]       TOLERANCE_RST       = 8'd0;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_DIAMETER_DEF = 7;

   // last row number before the row counter saturates
   localparam logic [CROW_W-1:0] ROW_LIMIT = 12'd4095;
   localparam logic [PIX_W-1:0]  PIX_MAX   = 8'd255;

   // result queue depth
   localparam int OUT_DEPTH = 4;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [CENSUS_W-1:0] census_bits;
      logic [CENSUS_W-1:0] confidence_bits;
      logic [CCOL_W-1:0]   center_column;
      logic [CROW_W-1:0]   center_row;
   } rsp_type;

   // what every window cell compares its sample against
   typedef struct packed {
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] low;
      logic [PIX_W-1:0] high;
   } band_type;

endpackage

FILE: hw/rtl/census_transform_with_confidence.sv
// ----------------------------------------------------------------------------
// census_transform_with_confidence: streaming census transform, square window
// Raster-order pixels in; for each interior pixel a census word and a
// confidence word over a d x d window (d = 1, 3, 5, 7) plus its coordinates.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake          word
//   req_*        in    req_valid/stall    pixel, frame_start
//   rsp_*        out   rsp_valid/stall    census, confidence, center col/row
//   csr_*        in    csr_write          index 0 width, 1 diameter, 2 tol
//
// One pixel per clock sustained while req_stall is low. A result passes
// line RAM read, window shift and compare into the result queue before
// it leaves the block. The rate is set by the line RAM, which does one
// read-modify-write of one column entry per pixel; back-to-back pixels in
// the same column (width 1) are forwarded around the RAM.
// Reset is synchronous; the line RAM is not cleared (no clearing pass), it
// is always written before any result depends on it.
// rsp_stall is absorbed by a 4-word queue; req_stall rises once queued
// plus in-flight words reach the queue depth.
// ----------------------------------------------------------------------------
module census_transform_with_confidence #(
   parameter int MAX_WIDTH    = ctc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_DIAMETER = ctc_pkg::MAX_DIAMETER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ctc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ctc_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [ctc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctc_pkg::CSR_W-1:0]     csr_data
);
   import ctc_pkg::*;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int EW_W      = $clog2(MAX_WIDTH+1);
   localparam int CMP_W     = (EW_W > WIDTH_CFG_W) ? EW_W : WIDTH_CFG_W;
   localparam int LINE_ROWS = MAX_DIAMETER - 1;
   localparam int LINE_W    = PIX_W * LINE_ROWS;
   localparam int TOP_D     = (MAX_DIAMETER - 1) | 1;    // largest odd diameter
   localparam int NOPT      = (TOP_D + 1) / 2;            // number of odd sizes
   localparam int KW        = (NOPT > 1) ? $clog2(NOPT) : 1;
   localparam int FIFO_CW   = $clog2(OUT_DEPTH+1);
   localparam int INF_W     = FIFO_CW + 1;
   localparam int RSP_W     = $bits(rsp_type);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [WIDTH_CFG_W-1:0] width_cfg_ff, width_cfg_in;
   logic [DIAM_W-1:0]      diam_cfg_ff, diam_cfg_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;

   always_comb begin
      width_cfg_in = width_cfg_ff;
      diam_cfg_in  = diam_cfg_ff;
      tol_in       = tol_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     width_cfg_in = csr_data[WIDTH_CFG_W-1:0];
            CSR_WINDOW_DIAMETER: diam_cfg_in  = csr_data[DIAM_W-1:0];
            CSR_TOLERANCE:       tol_in       = csr_data[TOL_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff <= IMAGE_WIDTH_RST;
         diam_cfg_ff  <= WINDOW_DIAMETER_RST;
         tol_ff       <= TOLERANCE_RST;
      end else begin
         width_cfg_ff <= width_cfg_in;
         diam_cfg_ff  <= diam_cfg_in;
         tol_ff       <= tol_in;
      end
   end

   // effective width: zero acts as one, clamp at the line RAM depth
   logic [EW_W-1:0]   eff_width;
   logic [DIAM_W-1:0] d_odd, d_eff, d_less1;
   logic [KW-1:0]     opt_sel;

   always_comb begin
      if (width_cfg_ff == '0) begin
         eff_width = EW_W'(1);
      end else if (CMP_W'(width_cfg_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_width = EW_W'(MAX_WIDTH);
      end else begin
         eff_width = EW_W'(width_cfg_ff);
      end
   end

   // diameter: force odd, clamp to the largest odd size the window holds
   assign d_odd   = diam_cfg_ff | DIAM_W'(1);
   assign d_eff   = (d_odd > DIAM_W'(TOP_D)) ? DIAM_W'(TOP_D) : d_odd;
   assign d_less1 = d_eff - DIAM_W'(1);
   assign opt_sel = KW'(d_eff >> 1);

   // ---------------------------------------------------------------
   // position counters, updated as each word is taken
   // ---------------------------------------------------------------
   logic                req_fire;
   logic [COL_W-1:0]    col_ff, col_in, cur_col;
   logic [CROW_W-1:0]   row_ff, row_in, cur_row;
   logic                ovf_ff, ovf_in, cur_ovf;
   logic                emit_now, row_end;
   logic [DIAM_W-1:0]   radius;

   assign req_fire = req_valid && !req_stall;

   // frame start clears the position before the pixel is placed
   assign cur_col = req_data.frame_start ? '0 : col_ff;
   assign cur_row = req_data.frame_start ? '0 : row_ff;
   assign cur_ovf = req_data.frame_start ? 1'b0 : ovf_ff;
   assign radius  = d_eff >> 1;

   // a result once the full window lies inside the image
   assign emit_now = !cur_ovf && (cur_row >= CROW_W'(d_less1))
                     && (cur_col >= COL_W'(d_less1));
   assign row_end  = (EW_W'(cur_col) + EW_W'(1)) >= eff_width;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ovf_in = ovf_ff;
      if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            if (cur_row >= ROW_LIMIT) begin
               row_in = ROW_LIMIT;   // saturate, silence until next frame
               ovf_in = 1'b1;
            end else begin
               row_in = cur_row + CROW_W'(1);
               ovf_in = cur_ovf;
            end
         end else begin
            col_in = cur_col + COL_W'(1);
            row_in = cur_row;
            ovf_in = cur_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ovf_ff <= ovf_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: line RAM entry for this column arrives
   // each RAM entry holds the last LINE_ROWS pixels of one column,
   // oldest row in the low byte
   // ---------------------------------------------------------------
   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_pixel_ff, s1_pixel_in;
   logic [COL_W-1:0]    s1_col_ff, s1_col_in;
   logic                s1_emit_ff, s1_emit_in;
   logic [CCOL_W-1:0]   s1_ccol_ff, s1_ccol_in;
   logic [CROW_W-1:0]   s1_crow_ff, s1_crow_in;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [LINE_W-1:0]   fwd_data_ff, fwd_data_in;
   logic [LINE_W-1:0]   ram_rd_data, line_src, line_next;

   assign s1_valid_in = req_fire;
   assign s1_pixel_in = req_fire ? req_data.pixel : s1_pixel_ff;
   assign s1_col_in   = req_fire ? cur_col : s1_col_ff;
   assign s1_emit_in  = req_fire ? emit_now : s1_emit_ff;
   assign s1_ccol_in  = req_fire ? CCOL_W'(cur_col - COL_W'(radius)) : s1_ccol_ff;
   assign s1_crow_in  = req_fire ? (cur_row - CROW_W'(radius)) : s1_crow_ff;

   // same column on consecutive cycles: the RAM read misses the write
   assign fwd_hit_in  = req_fire && s1_valid_ff && (s1_col_ff == cur_col);
   assign fwd_data_in = s1_valid_ff ? line_next : fwd_data_ff;

   assign line_src  = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign line_next = {s1_pixel_ff, line_src[LINE_W-1:PIX_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s1_pixel_in;
      s1_col_ff   <= s1_col_in;
      s1_emit_ff  <= s1_emit_in;
      s1_ccol_ff  <= s1_ccol_in;
      s1_crow_ff  <= s1_crow_in;
      fwd_data_ff <= fwd_data_in;
   end

   ctc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_next),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // window: MAX_DIAMETER rows of cells, each row a shift chain fed on
   // the right by the new column (top = oldest line, bottom = new pixel)
   // ---------------------------------------------------------------
   logic [PIX_W-1:0] col_vec [MAX_DIAMETER];
   logic [PIX_W-1:0] win [MAX_DIAMETER][MAX_DIAMETER];
   logic [MAX_DIAMETER-1:0][MAX_DIAMETER-1:0] lt_bits, cf_bits;
   band_type         band;

   always_comb begin
      for (int i = 0; i < LINE_ROWS; i++) begin
         col_vec[i] = line_src[i*PIX_W +: PIX_W];
      end
      col_vec[MAX_DIAMETER-1] = s1_pixel_ff;
   end

   for (genvar gi = 0; gi < MAX_DIAMETER; gi++) begin : g_row
      for (genvar gj = 0; gj < MAX_DIAMETER; gj++) begin : g_col
         logic [PIX_W-1:0] feed;
         if (gj == MAX_DIAMETER-1) begin : g_edge
            assign feed = col_vec[gi];
         end else begin : g_inner
            assign feed = win[gi][gj+1];
         end
         ctc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (s1_valid_ff),
            .feed       (feed),
            .band       (band),
            .sample     (win[gi][gj]),
            .census_bit (lt_bits[gi][gj]),
            .conf_bit   (cf_bits[gi][gj])
         );
      end
   end

   // ---------------------------------------------------------------
   // stage 2: compare against the center, pack, push into the queue
   // ---------------------------------------------------------------
   logic                s2_valid_ff, s2_valid_in;
   logic [CCOL_W-1:0]   s2_ccol_ff, s2_ccol_in;
   logic [CROW_W-1:0]   s2_crow_ff, s2_crow_in;
   logic [PIX_W-1:0]    center_opt [NOPT];
   logic [CENSUS_W-1:0] cen_opt [NOPT];
   logic [CENSUS_W-1:0] conf_opt [NOPT];
   logic [PIX_W:0]      high_sum;
   rsp_type             result;

   assign s2_valid_in = s1_valid_ff && s1_emit_ff;
   assign s2_ccol_in  = s1_valid_ff ? s1_ccol_ff : s2_ccol_ff;
   assign s2_crow_in  = s1_valid_ff ? s1_crow_ff : s2_crow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ccol_ff <= s2_ccol_in;
      s2_crow_ff <= s2_crow_in;
   end

   // the window of size 2k+1 sits in the bottom-right corner; its center
   // is k cells in from that corner
   always_comb begin
      for (int k = 0; k < NOPT; k++) begin
         center_opt[k] = win[MAX_DIAMETER-1-k][MAX_DIAMETER-1-k];
      end
   end

   // band limits saturate at 0 and 255
   assign band.center = center_opt[opt_sel];
   assign band.low    = (band.center > tol_ff) ? band.center - tol_ff : '0;
   assign high_sum    = {1'b0, band.center} + {1'b0, tol_ff};
   assign band.high   = (high_sum > {1'b0, PIX_MAX}) ? PIX_MAX : high_sum[PIX_W-1:0];

   // top-left sample of the active window in the MSB of its d*d bits
   always_comb begin
      for (int k = 0; k < NOPT; k++) begin
         cen_opt[k]  = '0;
         conf_opt[k] = '0;
         for (int i = 0; i < MAX_DIAMETER; i++) begin
            for (int j = 0; j < MAX_DIAMETER; j++) begin
               if (i >= MAX_DIAMETER-(2*k+1) && j >= MAX_DIAMETER-(2*k+1)) begin
                  cen_opt[k][(2*k+1)*(2*k+1) - 1
                             - ((i - (MAX_DIAMETER-(2*k+1))) * (2*k+1)
                                + (j - (MAX_DIAMETER-(2*k+1))))] = lt_bits[i][j];
                  conf_opt[k][(2*k+1)*(2*k+1) - 1
                              - ((i - (MAX_DIAMETER-(2*k+1))) * (2*k+1)
                                 + (j - (MAX_DIAMETER-(2*k+1))))] = cf_bits[i][j];
               end
            end
         end
      end
   end

   assign result.census_bits     = cen_opt[opt_sel];
   assign result.confidence_bits = conf_opt[opt_sel];
   assign result.center_column   = s2_ccol_ff;
   assign result.center_row      = s2_crow_ff;

   // ---------------------------------------------------------------
   // result queue and input flow control
   // ---------------------------------------------------------------
   logic [FIFO_CW-1:0] fifo_count;
   logic [RSP_W-1:0]   fifo_out;
   logic [INF_W-1:0]   inflight;

   ctc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (result),
      .pop       (rsp_valid && !rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (fifo_out),
      .count     (fifo_count)
   );

   assign rsp_data = rsp_type'(fifo_out);

   // every word in the pipe may still produce a result: reserve its slot
   assign inflight  = INF_W'(fifo_count) + INF_W'(s1_valid_ff) + INF_W'(s2_valid_ff);
   assign req_stall = inflight >= INF_W'(OUT_DEPTH);

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_count < FIFO_CW'(OUT_DEPTH)))
      else $error("result pushed into a full queue");

   a_fwd_needs_write: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("line forward taken with no pending write");

   a_take_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("taken word missing from stage 1");

endmodule

FILE: hw/rtl/ctc_ram.sv
// ----------------------------------------------------------------------------
// ctc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ctc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/ctc_cell.sv
// ----------------------------------------------------------------------------
// ctc_cell: one window cell
// Holds one sample, takes its right neighbor's sample on shift, and
// compares its sample against the window center and tolerance band.
// ----------------------------------------------------------------------------
module ctc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  logic [ctc_pkg::PIX_W-1:0] feed,
   input  ctc_pkg::band_type       band,
   output logic [ctc_pkg::PIX_W-1:0] sample,
   output logic                    census_bit,
   output logic                    conf_bit
);
   import ctc_pkg::*;

   logic [PIX_W-1:0] sample_ff;
   logic [PIX_W-1:0] sample_in;

   assign sample_in = shift ? feed : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample     = sample_ff;
   assign census_bit = sample_ff < band.center;
   assign conf_bit   = (sample_ff <= band.low) || (sample_ff >= band.high);
endmodule

FILE: hw/rtl/ctc_fifo.sv
// ----------------------------------------------------------------------------
// ctc_fifo: small result queue
// Register-based FIFO; the writer never pushes when full.
// ----------------------------------------------------------------------------
module ctc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       out_valid,
   output logic [WIDTH-1:0]           out_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;
endmodule
